// ===== design/esoc_pkg.sv =====
// shared constants, codes and saturation helpers for the epoch sync offset controller
`default_nettype none
package esoc_pkg;

  localparam int DEF_TIME_BITS = 32;

  // operation codes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_RECV  = 3'd1;
  localparam logic [2:0] OP_CHECK = 3'd2;
  localparam logic [2:0] OP_END   = 3'd3;
  localparam logic [2:0] OP_SEND  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_AHEAD = 2'd1;
  localparam logic [1:0] ST_LATE  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  // epoch end events
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SYNCED = 2'd1;
  localparam logic [1:0] EV_END    = 2'd2;

  // pre-end decisions
  localparam logic [1:0] DEC_WAIT  = 2'd0;
  localparam logic [1:0] DEC_EARLY = 2'd1;
  localparam logic [1:0] DEC_DELAY = 2'd2;

  // register indexes
  localparam logic [2:0] REG_INIT_INTERVAL   = 3'd0;
  localparam logic [2:0] REG_RUN_INTERVAL    = 3'd1;
  localparam logic [2:0] REG_INIT_SYNC_START = 3'd2;
  localparam logic [2:0] REG_RUN_SYNC_START  = 3'd3;
  localparam logic [2:0] REG_SYNCED_EPOCH    = 3'd4;
  localparam logic [2:0] REG_TX_DLY          = 3'd5;
  localparam logic [2:0] REG_LATE_THRESHOLD  = 3'd6;
  localparam logic [2:0] REG_ADJUST_LIMIT    = 3'd7;

  // register reset values
  localparam logic [30:0] RST_INTERVAL   = 31'd1280;
  localparam logic [30:0] RST_SYNC_START = 31'd128;
  localparam logic [14:0] RST_SYNCED     = 15'd10;
  localparam logic [7:0]  RST_TX_DLY     = 8'd0;
  localparam logic [30:0] RST_LATE       = 31'd128;
  localparam logic [30:0] RST_ADJUST     = 31'd64;

  localparam logic signed [31:0] SAT_HI = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_LO = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return SAT_HI;
    end else if (v < -64'sd2147483648) begin
      return SAT_LO;
    end
    return v[31:0];
  endfunction

  function automatic logic [30:0] clip31(input logic signed [63:0] v);
    if (v < 64'sd0) begin
      return 31'd0;
    end else if (v > 64'sd2147483647) begin
      return 31'h7FFFFFFF;
    end
    return v[30:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/esoc_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module esoc_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [NW-1:0] dvd_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dsr_q;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  assign trial = {rem_q, dvd_q[NW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      dvd_q <= {dvd_q[NW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

// ===== design/epoch_sync_offset_controller.sv =====
// epoch synchronizer: epoch timing, peer offset statistics and deadline correction
// Usage: one operation word enters on the in channel (valid/ready) and one result
// word leaves on the out channel (valid/ready). Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
// Sequencing: start, send stamp, the synced epoch end, stamps that are discarded or
// flagged, and epoch ends and checks with empty statistics pass from accept through
// the prepare state straight to apply, as does a stamp one epoch behind; several
// epochs behind adds the multiply and post states. A same-epoch stamp, a pre-end
// check with statistics, and an ordinary epoch end with statistics go through the
// shared serial divider, with setup states before it and finish states after it.
// The block takes a word only while its sequencer is idle, not before the last
// word has reached apply. A finished result sits in the output register;
// the next word may be accepted meanwhile, and it waits before its update until
// the output register is free, so a stalled receiver holds the block.
// Reset clears the epoch count, times and statistics and loads register defaults.
`default_nettype none
module epoch_sync_offset_controller #(
  parameter int TIME_BITS = esoc_pkg::DEF_TIME_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [30:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         operation_i,
  input  wire logic [30:0]        now_i,
  input  wire logic [14:0]        peer_epoch_i,
  input  wire logic [30:0]        peer_elapsed_i,
  input  wire logic [30:0]        peer_remaining_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [31:0]      offset_o,
  output logic [1:0]              event_res_o,
  output logic [1:0]              decision_o,
  output logic signed [31:0]      shift_o,
  output logic [14:0]             epoch_number_o,
  output logic [30:0]             elapsed_o,
  output logic [30:0]             remaining_o,
  output logic                    send_allowed_o
);

  localparam int TB  = TIME_BITS;
  localparam int DVW = (TB > 16) ? TB : 16;
  localparam int QW  = 64;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_DIVGO, S_DIV, S_POST, S_ADJ, S_APPLY
  } state_e;

  function automatic logic signed [63:0] sx(input logic [TB-1:0] v);
    return 64'($signed(v));
  endfunction

  // configuration
  logic [30:0] init_ival_q, run_ival_q, init_ss_q, run_ss_q, late_q, lim_q;
  logic [14:0] syn_q;
  logic [7:0]  tx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_ival_q <= esoc_pkg::RST_INTERVAL;
      run_ival_q  <= esoc_pkg::RST_INTERVAL;
      init_ss_q   <= esoc_pkg::RST_SYNC_START;
      run_ss_q    <= esoc_pkg::RST_SYNC_START;
      syn_q       <= esoc_pkg::RST_SYNCED;
      tx_q        <= esoc_pkg::RST_TX_DLY;
      late_q      <= esoc_pkg::RST_LATE;
      lim_q       <= esoc_pkg::RST_ADJUST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esoc_pkg::REG_INIT_INTERVAL:   init_ival_q <= cfg_data_i;
        esoc_pkg::REG_RUN_INTERVAL:    run_ival_q  <= cfg_data_i;
        esoc_pkg::REG_INIT_SYNC_START: init_ss_q   <= cfg_data_i;
        esoc_pkg::REG_RUN_SYNC_START:  run_ss_q    <= cfg_data_i;
        esoc_pkg::REG_SYNCED_EPOCH:    syn_q       <= cfg_data_i[14:0];
        esoc_pkg::REG_TX_DLY:          tx_q        <= cfg_data_i[7:0];
        esoc_pkg::REG_LATE_THRESHOLD:  late_q      <= cfg_data_i;
        esoc_pkg::REG_ADJUST_LIMIT:    lim_q       <= cfg_data_i;
      endcase
    end
  end

  // sequencer and block state
  state_e state_q;
  logic [14:0]        epoch_q;
  logic [TB-1:0]      start_q, end_q, dl_q;
  logic signed [31:0] sum_q, max_q, min_q;
  logic [15:0]        cnt_q;

  // latched word and work registers
  logic [2:0]         op_q;
  logic [TB-1:0]      now_q;
  logic [14:0]        pep_q;
  logic [30:0]        pel_q, prem_q;
  logic [1:0]         status_q;
  logic               take_q, sev_q, neg_q, avg_ok_q, adj_en_q;
  logic signed [31:0] off_q, avg_q, mul_a_q;
  logic [30:0]        mul_b_q;
  logic signed [63:0] prod_q;
  logic signed [33:0] adj_q;

  // result register
  logic               out_valid_q;
  logic [1:0]         status_oq, event_oq, decision_oq;
  logic signed [31:0] offset_oq, shift_oq;
  logic [14:0]        epoch_oq;
  logic [30:0]        elapsed_oq, remaining_oq;
  logic               allowed_oq;

  // divider
  logic          dv_start, dv_busy, dv_done;
  logic [QW-1:0] dv_dividend, dv_quot;
  logic [DVW-1:0] dv_divisor;
  logic          dv_neg;

  // time differences and derived values
  logic [63:0]        now64;
  logic [TB-1:0]      t_end_now, t_now_end, t_now_start, t_now_dl;
  logic               running;
  logic [30:0]        ival;
  logic signed [15:0] ep_gap;
  logic [14:0]        ndist;
  logic signed [31:0] off_near, dval;
  logic               stats_nz;
  logic signed [63:0] prod_c;
  logic [63:0]        prod_mag;
  logic [31:0]        sum_mag;
  logic [63:0]        el64, cnt64;
  logic signed [63:0] qs;
  logic signed [32:0] avg2, avg33, neg33;
  logic [32:0]        h2, sh2;
  logic signed [33:0] adj_raw, lim34;
  logic               adj_cond;
  logic signed [33:0] adj_clamp;
  logic [14:0]        epoch_inc;
  logic [TB-1:0]      dl_start, dl_sync, dl_plus, dl_fin;
  logic [63:0]        ival64, adj64, sh64, init64, run64;
  logic signed [63:0] rem64;

  assign now64       = {33'd0, now_i};
  assign t_end_now   = end_q - now_q;
  assign t_now_end   = now_q - end_q;
  assign t_now_start = now_q - start_q;
  assign t_now_dl    = now_q - dl_q;
  assign running     = epoch_q > syn_q;
  assign ival        = running ? run_ival_q : init_ival_q;
  assign ep_gap      = $signed({1'b0, epoch_q}) - $signed({1'b0, pep_q});
  assign ndist       = pep_q - epoch_q;
  assign off_near    = esoc_pkg::sat32(sx(t_end_now) + $signed({33'd0, pel_q}));
  assign dval        = esoc_pkg::sat32(sx(t_end_now) - $signed({33'd0, prem_q}));
  assign stats_nz    = (sum_q != 32'sd0) && (cnt_q != 16'd0);

  assign prod_c   = mul_a_q * $signed({1'b0, mul_b_q});
  assign prod_mag = prod_q[63] ? (~prod_q + 64'd1) : prod_q;
  assign sum_mag  = sum_q[31] ? (~sum_q + 32'd1) : sum_q;
  assign el64     = {{(64-TB){1'b0}}, t_now_start};
  assign cnt64    = {48'd0, cnt_q};

  assign dv_start    = (state_q == S_DIVGO);
  assign dv_dividend = (op_q == esoc_pkg::OP_RECV) ? prod_mag : {32'd0, sum_mag};
  assign dv_divisor  = (op_q == esoc_pkg::OP_RECV) ? el64[DVW-1:0] : cnt64[DVW-1:0];
  assign dv_neg      = (op_q == esoc_pkg::OP_RECV) ? prod_q[63] : sum_q[31];

  esoc_div #(
    .NW(QW),
    .DW(DVW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (dv_start),
    .dividend_i(dv_dividend),
    .divisor_i (dv_divisor),
    .busy_o    (dv_busy),
    .done_o    (dv_done),
    .quot_o    (dv_quot)
  );

  assign qs = neg_q ? -$signed(dv_quot) : $signed(dv_quot);

  // epoch end correction: -(avg + tx delay)/2 truncated toward zero, clamped
  assign avg2      = $signed({avg_q[31], avg_q}) + $signed({25'd0, tx_q});
  assign h2        = (avg2[32] ? (~avg2 + 33'd1) : avg2) >> 1;
  assign adj_raw   = (avg2 > 33'sd0) ? -$signed({1'b0, h2}) : $signed({1'b0, h2});
  assign lim34     = $signed({3'b0, lim_q});
  assign adj_cond  = (avg2 < -33'sd1) || (avg2 > 33'sd1);
  assign adj_clamp = (adj_raw > lim34) ? lim34 : ((adj_raw < -lim34) ? -lim34 : adj_raw);

  // pre-end delay
  assign avg33 = $signed({avg_q[31], avg_q});
  assign neg33 = -avg33;
  assign sh2   = neg33 >> 1;
  assign sh64  = {31'd0, sh2};

  assign epoch_inc = epoch_q + 15'd1;
  assign ival64    = {33'd0, ival};
  assign init64    = {33'd0, init_ival_q};
  assign run64     = {33'd0, run_ival_q};
  assign adj64     = 64'(adj_q);
  assign dl_start  = now_q + init64[TB-1:0];
  assign dl_sync   = now_q + run64[TB-1:0];
  assign dl_plus   = dl_q + ival64[TB-1:0];
  assign dl_fin    = adj_en_q ? (dl_plus + adj64[TB-1:0]) : dl_plus;
  assign rem64     = sx(t_end_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      epoch_q      <= '0;
      start_q      <= '0;
      end_q        <= '0;
      dl_q         <= '0;
      sum_q        <= '0;
      max_q        <= esoc_pkg::SAT_LO;
      min_q        <= esoc_pkg::SAT_HI;
      cnt_q        <= '0;
      op_q         <= '0;
      now_q        <= '0;
      pep_q        <= '0;
      pel_q        <= '0;
      prem_q       <= '0;
      status_q     <= esoc_pkg::ST_OK;
      take_q       <= 1'b0;
      sev_q        <= 1'b0;
      neg_q        <= 1'b0;
      avg_ok_q     <= 1'b0;
      adj_en_q     <= 1'b0;
      off_q        <= '0;
      avg_q        <= '0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      prod_q       <= '0;
      adj_q        <= '0;
      out_valid_q  <= 1'b0;
      status_oq    <= esoc_pkg::ST_OK;
      event_oq     <= esoc_pkg::EV_NONE;
      decision_oq  <= esoc_pkg::DEC_WAIT;
      offset_oq    <= '0;
      shift_oq     <= '0;
      epoch_oq     <= '0;
      elapsed_oq   <= '0;
      remaining_oq <= '0;
      allowed_oq   <= 1'b0;
    end else begin
      // in the apply state the result register is reloaded below
      if (out_valid_q && out_ready_i && (state_q != S_APPLY)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= operation_i;
            now_q   <= now64[TB-1:0];
            pep_q   <= peer_epoch_i;
            pel_q   <= peer_elapsed_i;
            prem_q  <= peer_remaining_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          take_q   <= 1'b0;
          status_q <= esoc_pkg::ST_OK;
          avg_ok_q <= 1'b0;
          adj_en_q <= 1'b0;
          sev_q    <= 1'b0;
          state_q  <= S_APPLY;
          if (op_q == esoc_pkg::OP_RECV) begin
            if (ep_gap > 16'sd0) begin
              status_q <= esoc_pkg::ST_AHEAD;
            end else if (ep_gap == -16'sd1) begin
              off_q  <= off_near;
              take_q <= 1'b1;
            end else if (ep_gap < -16'sd1) begin
              mul_a_q <= $signed({17'd0, ndist});
              mul_b_q <= ival;
              sev_q   <= 1'b1;
              state_q <= S_MUL;
            end else if (sx(t_now_end) > 64'sd0) begin
              status_q <= esoc_pkg::ST_LATE;
            end else if (sx(t_now_start) <= 64'sd0) begin
              status_q <= esoc_pkg::ST_ZERO;
            end else begin
              mul_a_q <= dval;
              mul_b_q <= ival;
              state_q <= S_MUL;
            end
          end else if (op_q == esoc_pkg::OP_CHECK) begin
            if ((sx(t_now_dl) < 64'sd0) && stats_nz) begin
              avg_ok_q <= 1'b1;
              state_q  <= S_DIVGO;
            end
          end else if (op_q == esoc_pkg::OP_END) begin
            if ((epoch_q != syn_q) && stats_nz) begin
              avg_ok_q <= 1'b1;
              state_q  <= S_DIVGO;
            end
          end
        end
        S_MUL: begin
          prod_q  <= prod_c;
          state_q <= sev_q ? S_POST : S_DIVGO;
        end
        S_DIVGO: begin
          neg_q   <= dv_neg;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (op_q == esoc_pkg::OP_RECV) begin
            off_q   <= sev_q ? esoc_pkg::sat32(prod_q) : esoc_pkg::sat32(qs);
            take_q  <= 1'b1;
            state_q <= S_APPLY;
          end else begin
            avg_q   <= qs[31:0];
            state_q <= (op_q == esoc_pkg::OP_END) ? S_ADJ : S_APPLY;
          end
        end
        S_ADJ: begin
          adj_en_q <= adj_cond;
          adj_q    <= adj_clamp;
          state_q  <= S_APPLY;
        end
        S_APPLY: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
            status_oq    <= esoc_pkg::ST_OK;
            event_oq     <= esoc_pkg::EV_NONE;
            decision_oq  <= esoc_pkg::DEC_WAIT;
            offset_oq    <= '0;
            shift_oq     <= '0;
            epoch_oq     <= epoch_q;
            elapsed_oq   <= '0;
            remaining_oq <= '0;
            allowed_oq   <= 1'b0;
            case (op_q)
              esoc_pkg::OP_START: begin
                epoch_q  <= '0;
                epoch_oq <= '0;
                start_q  <= now_q;
                dl_q     <= dl_start;
                end_q    <= dl_start;
                sum_q    <= '0;
                cnt_q    <= '0;
                max_q    <= esoc_pkg::SAT_LO;
                min_q    <= esoc_pkg::SAT_HI;
              end
              esoc_pkg::OP_RECV: begin
                status_oq <= status_q;
                if (take_q) begin
                  offset_oq <= off_q;
                  if (off_q > max_q) begin
                    max_q <= off_q;
                  end
                  if (off_q < min_q) begin
                    min_q <= off_q;
                  end
                  sum_q <= esoc_pkg::sat32(64'(sum_q) + 64'(off_q));
                  if (cnt_q != 16'hFFFF) begin
                    cnt_q <= cnt_q + 16'd1;
                  end
                end
              end
              esoc_pkg::OP_CHECK: begin
                if (avg_ok_q) begin
                  if (avg33 > $signed({2'b0, late_q})) begin
                    decision_oq <= esoc_pkg::DEC_EARLY;
                  end else if (avg33 < -$signed({2'b0, late_q})) begin
                    decision_oq <= esoc_pkg::DEC_DELAY;
                    shift_oq    <= sh2[31:0];
                    end_q       <= end_q + sh64[TB-1:0];
                  end
                end
              end
              esoc_pkg::OP_END: begin
                start_q  <= now_q;
                epoch_q  <= epoch_inc;
                epoch_oq <= epoch_inc;
                sum_q    <= '0;
                cnt_q    <= '0;
                max_q    <= esoc_pkg::SAT_LO;
                min_q    <= esoc_pkg::SAT_HI;
                if (epoch_q == syn_q) begin
                  dl_q     <= dl_sync;
                  end_q    <= dl_sync;
                  event_oq <= esoc_pkg::EV_SYNCED;
                end else begin
                  dl_q  <= dl_fin;
                  end_q <= dl_fin;
                  if (adj_en_q) begin
                    shift_oq <= adj_q[31:0];
                  end
                  if (epoch_inc > syn_q) begin
                    event_oq <= esoc_pkg::EV_END;
                  end
                end
              end
              esoc_pkg::OP_SEND: begin
                elapsed_oq   <= esoc_pkg::clip31(sx(t_now_start));
                remaining_oq <= esoc_pkg::clip31(rem64);
                allowed_oq   <= rem64 > $signed({33'd0, (running ? run_ss_q : init_ss_q)});
              end
              default: begin
                // unused codes leave the state alone
              end
            endcase
          end
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_oq;
  assign offset_o       = offset_oq;
  assign event_res_o    = event_oq;
  assign decision_o     = decision_oq;
  assign shift_o        = shift_oq;
  assign epoch_number_o = epoch_oq;
  assign elapsed_o      = elapsed_oq;
  assign remaining_o    = remaining_oq;
  assign send_allowed_o = allowed_oq;

  assert property (@(posedge clk_i) disable iff (!rst_ni) dv_busy |-> !in_ready_o)
    else $error("word accepted while the divider is busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sequencer did not leave idle after accept");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != esoc_pkg::ST_OK)) |-> (offset_o == 32'sd0))
    else $error("offset reported for a stamp that was not taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (cnt_q != 16'd0) |-> (min_q <= max_q))
    else $error("offset minimum above maximum");

endmodule
`default_nettype wire
